@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the luma histogram equalizer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
`define ASSERT_IMPLIES(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, cond)
`define ASSERT_IMPLIES(label, pre, post)
`endif
`endif

@@ rtl/core/lhe_pkg.sv @@
// Shared types and constants of the luma histogram equalizer
package lhe_pkg;
  localparam int COUNT_BITS = 22;
  localparam int LEVELS     = 256;
  localparam int LUMA_W     = 8;
  localparam int LVL_W      = $clog2(LEVELS);
  localparam int PROD_W     = COUNT_BITS + 8;
  localparam int DIVC_W     = $clog2(PROD_W);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_COUNT = 2'd1;
  localparam logic [1:0] ACT_MAP   = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  localparam logic [LUMA_W-1:0] OUT_MAX = 8'd255;

  typedef struct packed {
    logic [1:0]        action;
    logic [LUMA_W-1:0] luma;
  } lhe_item_t;
endpackage

@@ rtl/core/luma_histogram_equalizer.sv @@
// Map beat path: IDLE, OUT when passed through; IDLE, MRD, OUT with a built map.
// A 4-entry queue buffers input beats; the back end takes one item at a time.
// The first map beat after a clear or count, with a pixel total of two or more, builds
// the map: 256 levels, each via BRD, BACC, BDIV (one-bit-per-cycle divider) and BWR.
// Reset (rst_n low, synchronous) empties histogram, pixel total, queue and output.
module luma_histogram_equalizer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] luma
  input  logic [1:0] in_tuser,   // [1:0] action
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] new_luma
  output logic [0:0] out_tuser   // [0] status
);
  logic               q_valid, q_ready;
  lhe_pkg::lhe_item_t q_item;

  lhe_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .q_valid(q_valid), .q_item(q_item), .q_ready(q_ready)
  );

  lhe_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_item(q_item), .q_ready(q_ready),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );
endmodule

@@ rtl/core/lhe_front.sv @@
// Input acceptance, classification and item queue
module lhe_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] luma
  input  logic [1:0]        in_tuser,   // [1:0] action
  output logic              q_valid,
  output lhe_pkg::lhe_item_t q_item,
  input  logic              q_ready
);
  lhe_pkg::lhe_item_t queue_r [lhe_pkg::QUEUE_DEPTH];
  logic [lhe_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [lhe_pkg::QPTR_W:0]   cnt_r, cnt_nxt;
  logic push, pop;

  assign in_tready = (cnt_r != (lhe_pkg::QPTR_W+1)'(lhe_pkg::QUEUE_DEPTH));
  // drop unused action codes at the door
  assign push      = in_tvalid && in_tready && (in_tuser != lhe_pkg::ACT_NONE);
  assign q_valid   = (cnt_r != '0);
  assign pop       = q_valid && q_ready;
  assign q_item    = queue_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= '{action: in_tuser, luma: in_tdata};
    end
  end
endmodule

@@ rtl/core/lhe_back.sv @@
// Histogram, map build with serial divider, and result register
`include "assert_macros.svh"
module lhe_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  lhe_pkg::lhe_item_t q_item,
  output logic               q_ready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [7:0]         out_tdata,  // [7:0] new_luma
  output logic [0:0]         out_tuser   // [0] status
);
  localparam int CB = lhe_pkg::COUNT_BITS;
  localparam int PW = lhe_pkg::PROD_W;
  localparam int LW = lhe_pkg::LVL_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CRD  = 4'd1;
  localparam logic [3:0] S_CWR  = 4'd2;
  localparam logic [3:0] S_BRD  = 4'd3;
  localparam logic [3:0] S_BACC = 4'd4;
  localparam logic [3:0] S_BDIV = 4'd5;
  localparam logic [3:0] S_BWR  = 4'd6;
  localparam logic [3:0] S_MRD  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0]            state_r;
  lhe_pkg::lhe_item_t    item_r;
  logic [CB-1:0]         total_r;
  logic                  map_ready_r;
  logic [lhe_pkg::LEVELS-1:0] vld_r;
  logic [CB-1:0]         bin_mem [lhe_pkg::LEVELS];
  logic [CB-1:0]         bin_rd_r;
  logic [7:0]            lmap_mem [lhe_pkg::LEVELS];
  logic [7:0]            lmap_rd_r;
  logic [LW-1:0]         idx_r;
  logic [CB-1:0]         cum_r, base_r, den_r;
  logic                  seen_r;
  logic [PW-1:0]         num_r;
  logic [CB-1:0]         rem_r;
  logic [lhe_pkg::DIVC_W-1:0] div_cnt_r;
  logic [7:0]            res_luma_r;
  logic                  res_status_r;
  logic                  out_valid_r;
  logic [7:0]            out_luma_r;
  logic                  out_status_r;

  logic [LW-1:0] bin_raddr, cur_lvl;
  logic [CB-1:0] bin_cur, cum_nxt, base_nxt, diff;
  logic          seen_nxt;
  logic [CB:0]   sh;
  logic          qbit;
  logic [7:0]    qclamp;

  assign cur_lvl   = item_r.luma[LW-1:0];
  assign q_ready   = (state_r == S_IDLE);
  assign bin_raddr = (state_r == S_BRD) ? idx_r : cur_lvl;
  assign bin_cur   = vld_r[idx_r] ? bin_rd_r : '0;
  assign cum_nxt   = cum_r + bin_cur;
  assign seen_nxt  = seen_r || (bin_cur != '0);
  assign base_nxt  = (!seen_r && (bin_cur != '0)) ? cum_nxt : base_r;
  assign diff      = (seen_nxt && (cum_nxt > base_nxt)) ? (cum_nxt - base_nxt) : '0;
  assign sh        = {rem_r, num_r[PW-1]};
  assign qbit      = (sh >= {1'b0, den_r});
  assign qclamp    = (num_r > PW'(lhe_pkg::OUT_MAX)) ? lhe_pkg::OUT_MAX : num_r[7:0];

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_luma_r;
  assign out_tuser[0] = out_status_r;

  always_ff @(posedge clk) begin
    if (state_r == S_CWR && total_r != '1) begin
      bin_mem[cur_lvl] <= (vld_r[cur_lvl] ? bin_rd_r : '0) + 1'b1;
    end
    bin_rd_r <= bin_mem[bin_raddr];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_BWR) begin
      lmap_mem[idx_r] <= qclamp;
    end
    lmap_rd_r <= lmap_mem[cur_lvl];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      map_ready_r <= 1'b0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            item_r <= q_item;
            case (q_item.action)
              lhe_pkg::ACT_CLEAR: begin
                vld_r       <= '0;
                total_r     <= '0;
                map_ready_r <= 1'b0;
              end
              lhe_pkg::ACT_COUNT: begin
                map_ready_r <= 1'b0;
                state_r     <= S_CRD;
              end
              lhe_pkg::ACT_MAP: begin
                if (total_r < CB'(2)) begin
                  res_luma_r   <= q_item.luma;
                  res_status_r <= 1'b1;
                  state_r      <= S_OUT;
                end else if (!map_ready_r) begin
                  idx_r   <= '0;
                  cum_r   <= '0;
                  base_r  <= '0;
                  seen_r  <= 1'b0;
                  den_r   <= total_r - 1'b1;
                  state_r <= S_BRD;
                end else begin
                  state_r <= S_MRD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_CRD: begin
          state_r <= S_CWR;
        end
        S_CWR: begin
          if (total_r != '1) begin
            total_r        <= total_r + 1'b1;
            vld_r[cur_lvl] <= 1'b1;
          end
          state_r <= S_IDLE;
        end
        S_BRD: begin
          state_r <= S_BACC;
        end
        S_BACC: begin
          cum_r     <= cum_nxt;
          base_r    <= base_nxt;
          seen_r    <= seen_nxt;
          num_r     <= {diff, 8'd0} - PW'(diff);
          rem_r     <= '0;
          div_cnt_r <= '0;
          state_r   <= S_BDIV;
        end
        S_BDIV: begin
          rem_r     <= qbit ? CB'(sh - {1'b0, den_r}) : sh[CB-1:0];
          num_r     <= {num_r[PW-2:0], qbit};
          div_cnt_r <= div_cnt_r + 1'b1;
          if (div_cnt_r == lhe_pkg::DIVC_W'(PW - 1)) begin
            state_r <= S_BWR;
          end
        end
        S_BWR: begin
          if (idx_r == LW'(lhe_pkg::LEVELS - 1)) begin
            map_ready_r <= 1'b1;
            state_r     <= S_MRD;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_BRD;
          end
        end
        S_MRD: begin
          res_status_r <= 1'b0;
          state_r      <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r  <= 1'b1;
            out_luma_r   <= res_status_r ? res_luma_r : lmap_rd_r;
            out_status_r <= res_status_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_IMPLIES(a_ready_total, map_ready_r, total_r >= CB'(2))
  `ASSERT_IMPLIES(a_quot_range, state_r == S_BWR, num_r <= PW'(lhe_pkg::OUT_MAX))
  `ASSERT_IMPLIES(a_mapped_total, state_r == S_OUT && !res_status_r, map_ready_r)
  `ASSERT_IMPLIES(a_div_steps, state_r == S_BDIV, div_cnt_r < lhe_pkg::DIVC_W'(PW))
endmodule
